// ===== src/rttb_pkg.sv =====
package rttb_pkg;

  localparam int NUM_HANDLES_DEFAULT = 5;
  localparam int CountW = 3;

  localparam logic [15:0] RELOAD_DEFAULT = 16'd64636;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [31:0] NO_HANDLE_CODE = 32'h0000_00FF;

  localparam logic [2:0] REQ_TICK         = 3'd0;
  localparam logic [2:0] REQ_ALLOC        = 3'd1;
  localparam logic [2:0] REQ_CLEAR_HANDLE = 3'd2;
  localparam logic [2:0] REQ_READ_HANDLE  = 3'd3;
  localparam logic [2:0] REQ_READ_GLOBAL  = 3'd4;
  localparam logic [2:0] REQ_CLEAR_GLOBAL = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE_FREE  = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] handle;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        ms_tick;
  } res_t;

endpackage

// ===== src/rttb_in_reg.sv =====
module rttb_in_reg
  import rttb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic req_valid,
  output req_t req
);

  logic held;

  // stage empties when the result side can take it
  assign in_ready  = !held || advance;
  assign req_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

endmodule

// ===== src/rttb_core.sv =====
module rttb_core
  import rttb_pkg::*;
#(
  parameter int NUM_HANDLES = NUM_HANDLES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_reload,
  input  logic        fire,
  input  req_t        req,
  output res_t        res
);

  logic [15:0]       reload_value;
  logic [15:0]       tick_counter;
  logic [15:0]       tick_counter_next;
  logic [15:0]       global_ms;
  logic [15:0]       global_ms_next;
  logic [31:0]       counters      [NUM_HANDLES];
  logic [31:0]       counters_next [NUM_HANDLES];
  logic [CountW-1:0] in_use;
  logic [CountW-1:0] in_use_next;
  logic              handle_ok;
  logic              overflow;
  logic [31:0]       read_sel;

  assign handle_ok = (req.handle < in_use) && (32'(req.handle) < 32'(NUM_HANDLES));
  assign overflow  = (tick_counter == TICK_MAX);

  always_comb begin
    read_sel = '0;
    for (int i = 0; i < NUM_HANDLES; i++) begin
      if (req.handle == CountW'(i)) begin
        read_sel = read_sel | counters[i];
      end
    end
  end

  always_comb begin
    tick_counter_next = tick_counter;
    global_ms_next    = global_ms;
    in_use_next       = in_use;
    for (int i = 0; i < NUM_HANDLES; i++) begin
      counters_next[i] = counters[i];
    end
    res = '{value: '0, status: ST_OK, ms_tick: 1'b0};

    case (req.req_type)
      REQ_TICK: begin
        if (overflow) begin
          tick_counter_next = reload_value;
          global_ms_next    = global_ms + 16'd1;
          res.ms_tick       = 1'b1;
          for (int i = 0; i < NUM_HANDLES; i++) begin
            if (CountW'(i) < in_use) begin
              counters_next[i] = counters[i] + 32'd1;
            end
          end
        end else begin
          tick_counter_next = tick_counter + 16'd1;
        end
      end
      REQ_ALLOC: begin
        if (32'(in_use) < 32'(NUM_HANDLES)) begin
          for (int i = 0; i < NUM_HANDLES; i++) begin
            if (in_use == CountW'(i)) begin
              counters_next[i] = '0;
            end
          end
          res.value   = 32'(in_use);
          in_use_next = in_use + CountW'(1);
        end else begin
          res.value  = NO_HANDLE_CODE;
          res.status = ST_NONE_FREE;
        end
      end
      REQ_CLEAR_HANDLE: begin
        if (handle_ok) begin
          for (int i = 0; i < NUM_HANDLES; i++) begin
            if (req.handle == CountW'(i)) begin
              counters_next[i] = '0;
            end
          end
        end else begin
          res.status = ST_BAD_HANDLE;
        end
      end
      REQ_READ_HANDLE: begin
        if (handle_ok) begin
          res.value = read_sel;
        end else begin
          res.status = ST_BAD_HANDLE;
        end
      end
      REQ_READ_GLOBAL: begin
        res.value = 32'(global_ms);
      end
      REQ_CLEAR_GLOBAL: begin
        global_ms_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value <= RELOAD_DEFAULT;
    end else if (cfg_write) begin
      reload_value <= cfg_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= RELOAD_DEFAULT;
      global_ms    <= '0;
      in_use       <= '0;
      for (int i = 0; i < NUM_HANDLES; i++) begin
        counters[i] <= '0;
      end
    end else if (fire) begin
      tick_counter <= tick_counter_next;
      global_ms    <= global_ms_next;
      in_use       <= in_use_next;
      for (int i = 0; i < NUM_HANDLES; i++) begin
        counters[i] <= counters_next[i];
      end
    end
  end

endmodule

// ===== src/rttb_out_reg.sv =====
module rttb_out_reg
  import rttb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  res_t res,
  output logic advance,
  output logic fire,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic full;

  assign advance   = !full || out_ready;
  assign fire      = req_valid && advance;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (advance) begin
      full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

endmodule

// ===== src/reload_tick_timer_bank_top.sv =====
// Timer bank driven by a stream of requests: clock ticks advance a 16-bit
// counter that reloads from reload_value on passing 0xFFFF and then bumps the
// global millisecond time and every allocated handle counter. One request is
// taken per cycle while the output is not stalled. An accepted request waits
// in the input register, and the edge on which it leaves applies the state
// update and loads the result register. A stalled output holds both.
// Each request's state change is done before the next request is evaluated.
// reload_value writes are always accepted and take effect at the next reload.
module reload_tick_timer_bank_top
  import rttb_pkg::*;
#(
  parameter int NUM_HANDLES = NUM_HANDLES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [2:0]  handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic        ms_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] reload_value
);

  req_t in_req;
  req_t req;
  res_t res;
  res_t out_res;
  logic req_valid;
  logic advance;
  logic fire;

  assign in_req    = '{req_type: req_type, handle: handle};
  assign cfg_ready = 1'b1;

  rttb_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  rttb_core #(
    .NUM_HANDLES (NUM_HANDLES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_reload (reload_value),
    .fire       (fire),
    .req        (req),
    .res        (res)
  );

  rttb_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .res       (res),
    .advance   (advance),
    .fire      (fire),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign value   = out_res.value;
  assign status  = out_res.status;
  assign ms_tick = out_res.ms_tick;

endmodule
